// ===== design/dlpg_pkg.sv =====
`default_nettype none

package dlpg_pkg;

   localparam int COORD_BITS = 10;
   localparam int FRAC_BITS  = 16;
   localparam int COLOR_BITS = 24;
   localparam int POS_W      = COORD_BITS + FRAC_BITS;
   localparam int STEP_W     = POS_W + 1;
   localparam int COUNT_W    = COORD_BITS + 1;
   localparam int DIV_CNT_W  = $clog2(POS_W);

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [COLOR_BITS-1:0] color_type;
   typedef logic [POS_W-1:0]      pos_type;
   typedef logic [STEP_W-1:0]     step_type;
   typedef logic [COUNT_W-1:0]    count_type;

   localparam logic CMD_START   = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;

   // control into the shared divider
   typedef struct packed {
      logic      start;
      pos_type   dividend;
      coord_type divisor;
   } div_ctrl_type;

   // status back from the shared divider
   typedef struct packed {
      logic    done;
      pos_type quotient;
   } div_status_type;

endpackage

`default_nettype wire

// ===== design/dlpg_req_if.sv =====
`default_nettype none

interface dlpg_req_if;
   import dlpg_pkg::*;

   logic      valid;
   logic      ready;
   logic      cmd;
   coord_type x_start;
   coord_type y_start;
   coord_type x_end;
   coord_type y_end;
   color_type pixel_color;

   modport source (
      output valid, cmd, x_start, y_start, x_end, y_end, pixel_color,
      input  ready
   );

   modport sink (
      input  valid, cmd, x_start, y_start, x_end, y_end, pixel_color,
      output ready
   );
endinterface

`default_nettype wire

// ===== design/dlpg_rsp_if.sv =====
`default_nettype none

interface dlpg_rsp_if;
   import dlpg_pkg::*;

   logic      valid;
   logic      ready;
   coord_type point_x;
   coord_type point_y;
   color_type point_color;
   logic      last;

   modport source (
      output valid, point_x, point_y, point_color, last,
      input  ready
   );

   modport sink (
      input  valid, point_x, point_y, point_color, last,
      output ready
   );
endinterface

`default_nettype wire

// ===== design/dda_line_point_generator_unit.sv =====
// DDA line point generator.
// Start transfer: first point is registered at once; then the shared serial divider
// forms both increments, x then y, and no transfer is taken until it is done.
// Zero-length lines skip the divide. Advance transfer: one point per cycle while
// the result side does not stall; each point is registered in the result register.
// Reset (synchronous, active high) clears control state; no line is active after it.
`default_nettype none

module dda_line_point_generator_unit (
   input  wire logic clock,
   input  wire logic reset,
   dlpg_req_if.sink  req_bus,
   dlpg_rsp_if.source rsp_bus
);
   import dlpg_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_X,
      ST_DIV_Y
   } state_type;

   localparam logic [FRAC_BITS-1:0] HALF_FRAC = FRAC_BITS'(1) << (FRAC_BITS - 1);
   localparam logic [FRAC_BITS-1:0] ZERO_FRAC = '0;

   state_type state_ff;
   logic      line_active_ff;
   // positions carry a built-in half LSB so rounding is a plain bit select
   pos_type   pos_x_ff;
   pos_type   pos_y_ff;
   step_type  step_x_ff;
   step_type  step_y_ff;
   count_type points_left_ff;
   color_type held_color_ff;
   coord_type steps_ff;
   coord_type mag_y_ff;
   logic      neg_x_ff;
   logic      neg_y_ff;

   logic      rsp_valid_ff;
   coord_type rsp_x_ff;
   coord_type rsp_y_ff;
   color_type rsp_color_ff;
   logic      rsp_last_ff;

   // start decode
   logic      neg_x_in;
   logic      neg_y_in;
   coord_type adx_in;
   coord_type ady_in;
   coord_type steps_in;

   // advance datapath
   pos_type   pos_x_in;
   pos_type   pos_y_in;
   count_type points_left_in;

   logic      accept;
   logic      start_go;
   logic      advance_go;

   step_type  quot_ext;
   step_type  step_in;

   div_ctrl_type   div_ctrl;
   div_status_type div_status;

   assign req_bus.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign accept        = req_bus.valid && req_bus.ready;
   assign start_go      = accept && (req_bus.cmd == CMD_START);
   assign advance_go    = accept && (req_bus.cmd == CMD_ADVANCE) && line_active_ff;

   always_comb begin
      neg_x_in = req_bus.x_end < req_bus.x_start;
      neg_y_in = req_bus.y_end < req_bus.y_start;
      adx_in   = neg_x_in ? (req_bus.x_start - req_bus.x_end)
                          : (req_bus.x_end - req_bus.x_start);
      ady_in   = neg_y_in ? (req_bus.y_start - req_bus.y_end)
                          : (req_bus.y_end - req_bus.y_start);
      steps_in = (adx_in > ady_in) ? adx_in : ady_in;
   end

   // step addition wraps at POS_W, so the increment's sign bit drops out
   always_comb begin
      pos_x_in       = pos_x_ff + step_x_ff[POS_W-1:0];
      pos_y_in       = pos_y_ff + step_y_ff[POS_W-1:0];
      points_left_in = points_left_ff - 1'b1;
   end

   // shared divider: x axis launched from the start transfer, y axis after x is done
   always_comb begin
      div_ctrl.start    = (start_go && (steps_in != '0))
                          || ((state_ff == ST_DIV_X) && div_status.done);
      div_ctrl.dividend = (state_ff == ST_IDLE) ? {adx_in, ZERO_FRAC}
                                                : {mag_y_ff, ZERO_FRAC};
      div_ctrl.divisor  = steps_ff;
   end

   always_comb begin
      quot_ext = {1'b0, div_status.quotient};
      if (((state_ff == ST_DIV_X) && neg_x_ff) || ((state_ff == ST_DIV_Y) && neg_y_ff)) begin
         step_in = '0 - quot_ext;
      end else begin
         step_in = quot_ext;
      end
   end

   dlpg_divider u_divider (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (div_ctrl),
      .status (div_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         line_active_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         pos_x_ff       <= '0;
         pos_y_ff       <= '0;
         step_x_ff      <= '0;
         step_y_ff      <= '0;
         points_left_ff <= '0;
         held_color_ff  <= '0;
      end else begin
         if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (start_go) begin
                  held_color_ff  <= req_bus.pixel_color;
                  pos_x_ff       <= {req_bus.x_start, HALF_FRAC};
                  pos_y_ff       <= {req_bus.y_start, HALF_FRAC};
                  step_x_ff      <= '0;
                  step_y_ff      <= '0;
                  points_left_ff <= {1'b0, steps_in};
                  line_active_ff <= steps_in != '0;
                  rsp_valid_ff   <= 1'b1;
                  rsp_last_ff    <= steps_in == '0;
                  if (steps_in != '0) begin
                     state_ff <= ST_DIV_X;
                  end
               end else if (advance_go) begin
                  pos_x_ff       <= pos_x_in;
                  pos_y_ff       <= pos_y_in;
                  points_left_ff <= points_left_in;
                  line_active_ff <= points_left_in != '0;
                  rsp_valid_ff   <= 1'b1;
                  rsp_last_ff    <= points_left_in == '0;
               end
            end
            ST_DIV_X: begin
               if (div_status.done) begin
                  step_x_ff <= step_in;
                  state_ff  <= ST_DIV_Y;
               end
            end
            ST_DIV_Y: begin
               if (div_status.done) begin
                  step_y_ff <= step_in;
                  state_ff  <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (start_go) begin
         steps_ff     <= steps_in;
         mag_y_ff     <= ady_in;
         neg_x_ff     <= neg_x_in;
         neg_y_ff     <= neg_y_in;
         rsp_x_ff     <= req_bus.x_start;
         rsp_y_ff     <= req_bus.y_start;
         rsp_color_ff <= req_bus.pixel_color;
      end else if (advance_go) begin
         rsp_x_ff     <= pos_x_in[POS_W-1:FRAC_BITS];
         rsp_y_ff     <= pos_y_in[POS_W-1:FRAC_BITS];
         rsp_color_ff <= held_color_ff;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.point_x     = rsp_x_ff;
   assign rsp_bus.point_y     = rsp_y_ff;
   assign rsp_bus.point_color = rsp_color_ff;
   assign rsp_bus.last        = rsp_last_ff;

endmodule

`default_nettype wire

// ===== design/dlpg_divider.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle, MSB first.
// Divisor must stay stable while busy.
module dlpg_divider (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire dlpg_pkg::div_ctrl_type  ctrl,
   output dlpg_pkg::div_status_type     status
);
   import dlpg_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] count_ff;
   pos_type              num_ff;
   pos_type              quot_ff;
   coord_type            rem_ff;

   logic [COORD_BITS:0]  trial;
   logic                 fits;
   logic [COORD_BITS:0]  diff;
   coord_type            rem_in;

   always_comb begin
      trial  = {rem_ff, num_ff[POS_W-1]};
      fits   = trial >= {1'b0, ctrl.divisor};
      diff   = trial - {1'b0, ctrl.divisor};
      // remainder stays below the divisor, so it fits COORD_BITS
      rem_in = fits ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.start) begin
            busy_ff  <= 1'b1;
            count_ff <= DIV_CNT_W'(POS_W - 1);
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         num_ff  <= ctrl.dividend;
         rem_ff  <= '0;
         quot_ff <= '0;
      end else if (busy_ff) begin
         num_ff  <= {num_ff[POS_W-2:0], 1'b0};
         rem_ff  <= rem_in;
         quot_ff <= {quot_ff[POS_W-2:0], fits};
      end
   end

   assign status.done     = done_ff;
   assign status.quotient = quot_ff;

endmodule

`default_nettype wire

// ===== verif/dda_line_point_generator_unit_tb.sv =====
`timescale 1ns / 1ps

module dda_line_point_generator_unit_tb;
   import dlpg_pkg::*;

   // Stimulus volume and run guards.
   localparam int ITEM_TARGET    = 550;
   localparam int WATCHDOG_LIMIT = 4000;
   // A start runs the serial divider for both axes before the next transfer.
   localparam int DRAIN_CYCLES   = 2 * POS_W + 8;

   // How a directed row is checked.
   typedef enum logic [1:0] {
      CHECK_MODEL,   // expected point comes from the line predictor
      CHECK_TYPED,   // expected point is written in the row
      CHECK_SILENT   // the transfer must produce no point
   } check_type;

   typedef struct packed {
      logic      cmd;
      coord_type x0;
      coord_type y0;
      coord_type x1;
      coord_type y1;
      color_type color;
   } request_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      color_type color;
      logic      last;
   } point_type;

   typedef struct packed {
      logic      cmd;
      coord_type x0;
      coord_type y0;
      coord_type x1;
      coord_type y1;
      color_type color;
      check_type how;
      coord_type px;
      coord_type py;
      color_type pc;
      logic      plast;
   } directed_row_type;

   // Predictor copy of the rasterizer state.
   typedef struct {
      logic      active;
      pos_type   pos_x;
      pos_type   pos_y;
      step_type  step_x;
      step_type  step_y;
      count_type points_left;
      color_type color;
   } pen_state_type;

   localparam pos_type HALF_PIXEL = pos_type'(1) << (FRAC_BITS - 1);
   localparam int DIRECTED_ROWS = 24;

   // Directed walk: idle advances, zero-length lines at both corners, full
   // diagonals, a restart over an active line, vertical and shallow lines.
   localparam directed_row_type DIRECTED_TABLE [0:DIRECTED_ROWS-1] = '{
      // advance straight after reset: nothing drawn
      '{CMD_ADVANCE, 0, 0, 0, 0, 24'h000000, CHECK_SILENT, 0, 0, 24'h000000, 1'b0},
      // zero-length line at the origin
      '{CMD_START, 0, 0, 0, 0, 24'h000000, CHECK_TYPED, 0, 0, 24'h000000, 1'b1},
      '{CMD_ADVANCE, 0, 0, 0, 0, 24'h000000, CHECK_SILENT, 0, 0, 24'h000000, 1'b0},
      // zero-length line at the far corner, full white
      '{CMD_START, 1023, 1023, 1023, 1023, 24'hFFFFFF, CHECK_TYPED,
        1023, 1023, 24'hFFFFFF, 1'b1},
      // full diagonal, walked two points then dropped
      '{CMD_START, 0, 0, 1023, 1023, 24'h123456, CHECK_TYPED, 0, 0, 24'h123456, 1'b0},
      '{CMD_ADVANCE, 0, 0, 0, 0, 24'h000000, CHECK_TYPED, 1, 1, 24'h123456, 1'b0},
      '{CMD_ADVANCE, 0, 0, 0, 0, 24'h000000, CHECK_MODEL, 0, 0, 24'h000000, 1'b0},
      // restart while active, anti-diagonal with negative x
      '{CMD_START, 1023, 0, 0, 1023, 24'hA5A5A5, CHECK_TYPED,
        1023, 0, 24'hA5A5A5, 1'b0},
      '{CMD_ADVANCE, 0, 0, 0, 0, 24'h000000, CHECK_TYPED, 1022, 1, 24'hA5A5A5, 1'b0},
      // shallow line, fractional y increment, walked to the end
      '{CMD_START, 5, 5, 8, 6, 24'h5A5A5A, CHECK_MODEL, 0, 0, 24'h000000, 1'b0},
      '{CMD_ADVANCE, 0, 0, 0, 0, 24'h000000, CHECK_MODEL, 0, 0, 24'h000000, 1'b0},
      '{CMD_ADVANCE, 0, 0, 0, 0, 24'h000000, CHECK_MODEL, 0, 0, 24'h000000, 1'b0},
      '{CMD_ADVANCE, 0, 0, 0, 0, 24'h000000, CHECK_MODEL, 0, 0, 24'h000000, 1'b0},
      // line finished: advance is ignored
      '{CMD_ADVANCE, 0, 0, 0, 0, 24'h000000, CHECK_SILENT, 0, 0, 24'h000000, 1'b0},
      // vertical line, zero x increment
      '{CMD_START, 10, 0, 10, 2, 24'h00FF00, CHECK_TYPED, 10, 0, 24'h00FF00, 1'b0},
      '{CMD_ADVANCE, 0, 0, 0, 0, 24'h000000, CHECK_MODEL, 0, 0, 24'h000000, 1'b0},
      '{CMD_ADVANCE, 0, 0, 0, 0, 24'h000000, CHECK_TYPED, 10, 2, 24'h00FF00, 1'b1},
      // anti-diagonal with negative y
      '{CMD_START, 0, 1023, 1023, 0, 24'h000001, CHECK_MODEL, 0, 0, 24'h000000, 1'b0},
      '{CMD_ADVANCE, 0, 0, 0, 0, 24'h000000, CHECK_MODEL, 0, 0, 24'h000000, 1'b0},
      // short line leftward, y crosses the half-pixel rounding point
      '{CMD_START, 3, 0, 0, 1, 24'h800000, CHECK_MODEL, 0, 0, 24'h000000, 1'b0},
      '{CMD_ADVANCE, 0, 0, 0, 0, 24'h000000, CHECK_MODEL, 0, 0, 24'h000000, 1'b0},
      '{CMD_ADVANCE, 0, 0, 0, 0, 24'h000000, CHECK_MODEL, 0, 0, 24'h000000, 1'b0},
      '{CMD_ADVANCE, 0, 0, 0, 0, 24'h000000, CHECK_MODEL, 0, 0, 24'h000000, 1'b0},
      '{CMD_ADVANCE, 0, 0, 0, 0, 24'h000000, CHECK_SILENT, 0, 0, 24'h000000, 1'b0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   dlpg_req_if req_bus ();
   dlpg_rsp_if rsp_bus ();

   dda_line_point_generator_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   pen_state_type pen;
   point_type     expected_points [$];
   int            items_taken  = 0;
   int            error_count  = 0;
   int            tx_idle_pct  = 13;
   int            rx_idle_pct  = 47;
   int            quiet_cycles = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Signed per-step increment: |delta| scaled by 2^FRAC_BITS, truncated
   // divide by the step count, negated for a decreasing axis.
   function automatic step_type slope_of(input coord_type from_c, input coord_type to_c,
                                         input coord_type span);
      coord_type mag;
      pos_type   quot;
      if (span == 0) return '0;
      mag  = (to_c >= from_c) ? to_c - from_c : from_c - to_c;
      quot = pos_type'({mag, {FRAC_BITS{1'b0}}}) / pos_type'(span);
      return (to_c < from_c) ? -{1'b0, quot} : {1'b0, quot};
   endfunction

   // Round half up to an integer pixel; the carry out of the top is dropped.
   function automatic coord_type pixel_of(input pos_type pos);
      logic [POS_W:0] sum;
      sum = {1'b0, pos} + HALF_PIXEL;
      return sum[POS_W-1:FRAC_BITS];
   endfunction

   // Applies one transfer to the pen state; returns 1 when a point is drawn.
   function automatic logic advance_pen(input request_type r, output point_type p);
      coord_type adx;
      coord_type ady;
      coord_type span;
      if (r.cmd == CMD_START) begin
         adx  = (r.x1 >= r.x0) ? r.x1 - r.x0 : r.x0 - r.x1;
         ady  = (r.y1 >= r.y0) ? r.y1 - r.y0 : r.y0 - r.y1;
         span = (adx > ady) ? adx : ady;
         pen.color       = r.color;
         pen.pos_x       = {r.x0, {FRAC_BITS{1'b0}}};
         pen.pos_y       = {r.y0, {FRAC_BITS{1'b0}}};
         pen.step_x      = slope_of(r.x0, r.x1, span);
         pen.step_y      = slope_of(r.y0, r.y1, span);
         pen.points_left = count_type'(span);
         pen.active      = (span != 0);
      end else begin
         if (!pen.active) return 1'b0;
         // sign extension above POS_W falls away in the wrap
         pen.pos_x       = pen.pos_x + pen.step_x[POS_W-1:0];
         pen.pos_y       = pen.pos_y + pen.step_y[POS_W-1:0];
         pen.points_left = pen.points_left - 1'b1;
         pen.active      = (pen.points_left != 0);
      end
      p.x     = pixel_of(pen.pos_x);
      p.y     = pixel_of(pen.pos_y);
      p.color = pen.color;
      p.last  = !pen.active;
      return 1'b1;
   endfunction

   // Random payload; on an advance the coordinates and colour are don't-care.
   function automatic request_type scramble(input logic cmd);
      request_type r;
      r.cmd   = cmd;
      r.x0    = coord_type'($urandom);
      r.y0    = coord_type'($urandom);
      r.x1    = coord_type'($urandom);
      r.y1    = coord_type'($urandom);
      r.color = color_type'($urandom);
      return r;
   endfunction

   // Drive one request, hold it until the transfer, then record what it draws.
   task automatic issue(input request_type r, input check_type how, input point_type typed);
      point_type p;
      logic      draws;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.cmd         <= r.cmd;
      req_bus.x_start     <= r.x0;
      req_bus.y_start     <= r.y0;
      req_bus.x_end       <= r.x1;
      req_bus.y_end       <= r.y1;
      req_bus.pixel_color <= r.color;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      draws = advance_pen(r, p);
      // ignored advances do not count toward the volume
      if (draws) items_taken++;
      case (how)
         CHECK_MODEL: begin
            if (draws) expected_points.push_back(p);
         end
         CHECK_TYPED: begin
            expected_points.push_back(typed);
         end
         default: ;
      endcase
   endtask

   // Hold the request side until every outstanding point has come back.
   task automatic drain_points();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (expected_points.size() != 0);
   endtask

   // Receiver stalls at the current rate.
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // Point checker: every transfer on the result side against the oldest
   // expectation, field by field.
   always @(posedge clock) begin
      point_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_points.size() == 0) begin
            $display("%0t: unexpected point x=%0d y=%0d color=%06h last=%0b", $time,
                     rsp_bus.point_x, rsp_bus.point_y, rsp_bus.point_color, rsp_bus.last);
            error_count++;
         end else begin
            want = expected_points.pop_front();
            if (rsp_bus.point_x !== want.x) begin
               $display("%0t: point_x expected %0d, got %0d", $time, want.x, rsp_bus.point_x);
               error_count++;
            end
            if (rsp_bus.point_y !== want.y) begin
               $display("%0t: point_y expected %0d, got %0d", $time, want.y, rsp_bus.point_y);
               error_count++;
            end
            if (rsp_bus.point_color !== want.color) begin
               $display("%0t: point_color expected %06h, got %06h", $time, want.color,
                        rsp_bus.point_color);
               error_count++;
            end
            if (rsp_bus.last !== want.last) begin
               $display("%0t: last expected %0b, got %0b", $time, want.last, rsp_bus.last);
               error_count++;
            end
         end
      end
   end

   // Watchdog: too long without a transfer on either side ends the run.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog, no transfer for %0d cycles", $time, quiet_cycles);
         $display("dda_line_point_generator_unit regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      request_type r;
      point_type   typed;
      int          phase;
      int          phase_now;
      int          span;
      int          x0;
      int          y0;
      int          x1;
      int          y1;
      int          walk;

      req_bus.valid       = 1'b0;
      req_bus.cmd         = CMD_START;
      req_bus.x_start     = '0;
      req_bus.y_start     = '0;
      req_bus.x_end       = '0;
      req_bus.y_end       = '0;
      req_bus.pixel_color = '0;
      pen = '{1'b0, '0, '0, '0, '0, '0, '0};
      phase = 0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed table.
      foreach (DIRECTED_TABLE[i]) begin
         r     = '{DIRECTED_TABLE[i].cmd, DIRECTED_TABLE[i].x0, DIRECTED_TABLE[i].y0,
                   DIRECTED_TABLE[i].x1, DIRECTED_TABLE[i].y1, DIRECTED_TABLE[i].color};
         typed = '{DIRECTED_TABLE[i].px, DIRECTED_TABLE[i].py, DIRECTED_TABLE[i].pc,
                   DIRECTED_TABLE[i].plast};
         issue(r, DIRECTED_TABLE[i].how, typed);
      end

      // Random lines: mostly short spans anywhere on the grid, a few long
      // ones. Most are walked to the last point, some are cut short by the
      // next start, and now and then an extra advance follows, on an idle pen if the walk ended.
      typed = '0;
      while (items_taken < ITEM_TARGET) begin
         phase_now = (items_taken * 3) / ITEM_TARGET;
         if (phase_now > 2) phase_now = 2;
         if (phase_now != phase) begin
            phase = phase_now;
            // pressure point: let the block run dry between idle profiles
            drain_points();
            case (phase)
               1: begin
                  tx_idle_pct = 47;
                  rx_idle_pct = 13;
               end
               default: begin
                  tx_idle_pct = 0;
                  rx_idle_pct = 0;
               end
            endcase
         end

         span = ($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(16);
         x0   = $urandom_range(1023);
         y0   = $urandom_range(1023);
         x1   = $urandom_range(1) ? x0 + $urandom_range(span) : x0 - $urandom_range(span);
         y1   = $urandom_range(1) ? y0 + $urandom_range(span) : y0 - $urandom_range(span);
         if (x1 < 0) x1 = 0;
         if (x1 > 1023) x1 = 1023;
         if (y1 < 0) y1 = 0;
         if (y1 > 1023) y1 = 1023;

         r    = scramble(CMD_START);
         r.x0 = coord_type'(x0);
         r.y0 = coord_type'(y0);
         r.x1 = coord_type'(x1);
         r.y1 = coord_type'(y1);
         issue(r, CHECK_MODEL, typed);

         walk = pen.points_left;
         if ($urandom_range(9) == 0) walk = $urandom_range(walk);
         repeat (walk) issue(scramble(CMD_ADVANCE), CHECK_MODEL, typed);
         if ($urandom_range(9) == 0) issue(scramble(CMD_ADVANCE), CHECK_MODEL, typed);
      end

      drain_points();
      // a start may still be dividing after its first point came back
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("dda_line_point_generator_unit regression: pass");
      end else begin
         $display("dda_line_point_generator_unit regression: fail");
      end
      $finish;
   end

endmodule
